// ===== design/eedp_pkg.sv =====
// ----------------------------------------------------------------------------
// Extended event descriptor parser package
// Field widths and byte role codes shared by the channel interfaces and the
// parser.
// ----------------------------------------------------------------------------
package eedp_pkg;

    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 4;
    localparam int ITEM_W  = 7;
    localparam int NUM_W   = 4;

    localparam logic [ROLE_W-1:0] PH_TAG       = 4'd0;
    localparam logic [ROLE_W-1:0] PH_LENGTH    = 4'd1;
    localparam logic [ROLE_W-1:0] PH_NUMBERS   = 4'd2;
    localparam logic [ROLE_W-1:0] PH_LANG      = 4'd3;
    localparam logic [ROLE_W-1:0] PH_ITEMS_LEN = 4'd4;
    localparam logic [ROLE_W-1:0] PH_DESC_LEN  = 4'd5;
    localparam logic [ROLE_W-1:0] PH_DESC_CHAR = 4'd6;
    localparam logic [ROLE_W-1:0] PH_ITEM_LEN  = 4'd7;
    localparam logic [ROLE_W-1:0] PH_ITEM_CHAR = 4'd8;
    localparam logic [ROLE_W-1:0] PH_TEXT_LEN  = 4'd9;
    localparam logic [ROLE_W-1:0] PH_TEXT_CHAR = 4'd10;
    localparam logic [ROLE_W-1:0] PH_TRAILING  = 4'd11;

    localparam logic [BYTE_W-1:0] LANG_CHARS = 8'd3;
    localparam logic [ITEM_W-1:0] ITEM_MAX   = 7'd127;

endpackage

// ===== design/eedp_if.sv =====
// ----------------------------------------------------------------------------
// Extended event descriptor parser channels
// Valid/ready interfaces for the raw byte stream and the tagged byte stream.
// ----------------------------------------------------------------------------
interface eedp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [eedp_pkg::BYTE_W-1:0]  data_byte;
    logic                         start_of_descriptor;

    modport source (output valid, output data_byte, output start_of_descriptor,
                    input ready);
    modport sink   (input valid, input data_byte, input start_of_descriptor,
                    output ready);
endinterface

interface eedp_role_if;
    logic                         valid;
    logic                         ready;
    logic [eedp_pkg::ROLE_W-1:0]  byte_role;
    logic [eedp_pkg::BYTE_W-1:0]  byte_value;
    logic [eedp_pkg::ITEM_W-1:0]  item_number;
    logic [eedp_pkg::BYTE_W-1:0]  char_position;
    logic [eedp_pkg::NUM_W-1:0]   this_number;
    logic [eedp_pkg::NUM_W-1:0]   final_number;
    logic                         end_of_descriptor;
    logic                         length_error;

    modport source (output valid, output byte_role, output byte_value,
                    output item_number, output char_position, output this_number,
                    output final_number, output end_of_descriptor,
                    output length_error, input ready);
    modport sink   (input valid, input byte_role, input byte_value,
                    input item_number, input char_position, input this_number,
                    input final_number, input end_of_descriptor,
                    input length_error, output ready);
endinterface

// ===== design/extended_event_descriptor_parser_top.sv =====
// ----------------------------------------------------------------------------
// Extended event descriptor parser
// Tags each byte of an extended event descriptor with its role and tracks
// lengths, item index, string position and descriptor numbers.
// ----------------------------------------------------------------------------
//  port         | dir  | contents
//  desc_stream  | sink | data_byte, start_of_descriptor
//  role_stream  | src  | byte_role, byte_value, item_number, char_position,
//               |      | this_number, final_number, end_of_descriptor,
//               |      | length_error
//
//  One transaction per cycle while the result is not stalled; the result is
//  registered and appears in the cycle after acceptance.
//  rst_n clears the parse state to trailing and empties the result register.
//  A stalled result holds; a new byte is taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
module extended_event_descriptor_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    eedp_byte_if.sink    desc_stream,
    eedp_role_if.source  role_stream
);

    localparam int BW = eedp_pkg::BYTE_W;
    localparam int RW = eedp_pkg::ROLE_W;
    localparam int IW = eedp_pkg::ITEM_W;
    localparam int NW = eedp_pkg::NUM_W;

    logic [RW-1:0] phase_reg,      phase_next;
    logic [BW-1:0] field_left_reg, field_left_next;
    logic [BW-1:0] items_left_reg, items_left_next;
    logic [BW-1:0] desc_left_reg,  desc_left_next;
    logic [IW-1:0] item_cnt_reg,   item_cnt_next;
    logic [BW-1:0] pos_cnt_reg,    pos_cnt_next;
    logic [BW-1:0] numbers_reg,    numbers_next;
    logic          error_reg,      error_next;

    logic          out_valid_reg;
    logic [RW-1:0] role_reg;
    logic [BW-1:0] value_reg;
    logic [IW-1:0] item_out_reg;
    logic [BW-1:0] pos_out_reg;
    logic [BW-1:0] numbers_out_reg;
    logic          end_out_reg;
    logic          error_out_reg;

    logic          accept;
    logic [BW-1:0] b;
    logic [RW-1:0] role;
    logic [BW-1:0] pos;
    logic          last;
    logic [BW-1:0] desc_dec;
    logic [BW-1:0] items_after;
    logic [BW-1:0] field_after;
    logic [IW-1:0] item_inc;
    logic [BW-1:0] pos_inc;

    assign desc_stream.ready = !out_valid_reg || role_stream.ready;
    assign accept = desc_stream.valid && desc_stream.ready;
    assign b = desc_stream.data_byte;

    assign desc_dec    = desc_left_reg - 8'd1;
    assign items_after = (items_left_reg == '0) ? items_left_reg : items_left_reg - 8'd1;
    assign field_after = (field_left_reg == '0) ? field_left_reg : field_left_reg - 8'd1;
    assign item_inc    = (item_cnt_reg < eedp_pkg::ITEM_MAX) ? item_cnt_reg + 7'd1
                                                             : item_cnt_reg;
    assign pos_inc     = pos_cnt_reg + 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        field_left_next = field_left_reg;
        items_left_next = items_left_reg;
        desc_left_next  = desc_left_reg;
        item_cnt_next   = item_cnt_reg;
        pos_cnt_next    = pos_cnt_reg;
        numbers_next    = numbers_reg;
        error_next      = error_reg;
        role            = phase_reg;
        pos             = '0;
        last            = 1'b0;

        if (desc_stream.start_of_descriptor)
        begin
            role            = eedp_pkg::PH_TAG;
            phase_next      = eedp_pkg::PH_LENGTH;
            field_left_next = '0;
            items_left_next = '0;
            desc_left_next  = '0;
            item_cnt_next   = '0;
            pos_cnt_next    = '0;
            numbers_next    = '0;
            error_next      = 1'b0;
        end
        else
        begin
            // descriptor length countdown for every role from numbers to text char
            if (phase_reg inside {[eedp_pkg::PH_NUMBERS:eedp_pkg::PH_TEXT_CHAR]})
            begin
                if (desc_left_reg == '0)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    desc_left_next = desc_dec;
                    last           = (desc_dec == '0);
                end
            end
            // item loop countdown
            if (phase_reg inside {[eedp_pkg::PH_DESC_LEN:eedp_pkg::PH_ITEM_CHAR]})
            begin
                items_left_next = items_after;
                if (items_left_reg == '0)
                begin
                    error_next = 1'b1;
                end
            end

            case (phase_reg)
                eedp_pkg::PH_LENGTH:
                begin
                    desc_left_next = b;
                    last           = (b == '0);
                    phase_next     = eedp_pkg::PH_NUMBERS;
                end
                eedp_pkg::PH_NUMBERS:
                begin
                    numbers_next = b;
                    pos_cnt_next = '0;
                    phase_next   = eedp_pkg::PH_LANG;
                end
                eedp_pkg::PH_LANG:
                begin
                    pos          = pos_cnt_reg;
                    pos_cnt_next = pos_inc;
                    if (pos_inc >= eedp_pkg::LANG_CHARS)
                    begin
                        phase_next = eedp_pkg::PH_ITEMS_LEN;
                    end
                end
                eedp_pkg::PH_ITEMS_LEN:
                begin
                    items_left_next = b;
                    phase_next = (b == '0) ? eedp_pkg::PH_TEXT_LEN : eedp_pkg::PH_DESC_LEN;
                end
                eedp_pkg::PH_DESC_LEN, eedp_pkg::PH_ITEM_LEN:
                begin
                    field_left_next = b;
                    pos_cnt_next    = '0;
                    if (b != '0)
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                    else if (phase_reg == eedp_pkg::PH_DESC_LEN)
                    begin
                        phase_next = eedp_pkg::PH_ITEM_LEN;
                    end
                    else
                    begin
                        item_cnt_next = item_inc;
                        phase_next = (items_after == '0) ? eedp_pkg::PH_TEXT_LEN
                                                         : eedp_pkg::PH_DESC_LEN;
                    end
                end
                eedp_pkg::PH_DESC_CHAR, eedp_pkg::PH_ITEM_CHAR:
                begin
                    pos             = pos_cnt_reg;
                    pos_cnt_next    = pos_inc;
                    field_left_next = field_after;
                    if (field_after == '0)
                    begin
                        if (phase_reg == eedp_pkg::PH_DESC_CHAR)
                        begin
                            phase_next = eedp_pkg::PH_ITEM_LEN;
                        end
                        else
                        begin
                            item_cnt_next = item_inc;
                            phase_next = (items_after == '0) ? eedp_pkg::PH_TEXT_LEN
                                                             : eedp_pkg::PH_DESC_LEN;
                        end
                    end
                end
                eedp_pkg::PH_TEXT_LEN:
                begin
                    field_left_next = b;
                    pos_cnt_next    = '0;
                    phase_next = (b == '0) ? eedp_pkg::PH_TRAILING : eedp_pkg::PH_TEXT_CHAR;
                end
                eedp_pkg::PH_TEXT_CHAR:
                begin
                    pos             = pos_cnt_reg;
                    pos_cnt_next    = pos_inc;
                    field_left_next = field_after;
                    if (field_after == '0)
                    begin
                        phase_next = eedp_pkg::PH_TRAILING;
                    end
                end
                default:
                begin
                    role       = eedp_pkg::PH_TRAILING;
                    phase_next = eedp_pkg::PH_TRAILING;
                    if (desc_left_reg != '0)
                    begin
                        desc_left_next = desc_dec;
                        last           = (desc_dec == '0);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= eedp_pkg::PH_TRAILING;
            field_left_reg <= '0;
            items_left_reg <= '0;
            desc_left_reg  <= '0;
            item_cnt_reg   <= '0;
            pos_cnt_reg    <= '0;
            numbers_reg    <= '0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                field_left_reg <= field_left_next;
                items_left_reg <= items_left_next;
                desc_left_reg  <= desc_left_next;
                item_cnt_reg   <= item_cnt_next;
                pos_cnt_reg    <= pos_cnt_next;
                numbers_reg    <= numbers_next;
                error_reg      <= error_next;
                out_valid_reg  <= 1'b1;
            end
            else if (role_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            role_reg        <= role;
            value_reg       <= b;
            item_out_reg    <= item_cnt_next;
            pos_out_reg     <= pos;
            numbers_out_reg <= numbers_next;
            end_out_reg     <= last;
            error_out_reg   <= error_next;
        end
    end

    assign role_stream.valid             = out_valid_reg;
    assign role_stream.byte_role         = role_reg;
    assign role_stream.byte_value        = value_reg;
    assign role_stream.item_number       = item_out_reg;
    assign role_stream.char_position     = pos_out_reg;
    assign role_stream.this_number       = numbers_out_reg[BW-1:BW-NW];
    assign role_stream.final_number      = numbers_out_reg[NW-1:0];
    assign role_stream.end_of_descriptor = end_out_reg;
    assign role_stream.length_error      = error_out_reg;

    a_start_tag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && desc_stream.start_of_descriptor
        |=> out_valid_reg && role_reg == eedp_pkg::PH_TAG && phase_reg == eedp_pkg::PH_LENGTH)
        else $error("start byte not tagged or parse not restarted");

    a_tag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && role_reg == eedp_pkg::PH_TAG
        |-> !error_out_reg && item_out_reg == '0 && numbers_out_reg == '0)
        else $error("tag transaction carries stale descriptor state");

    a_trailing_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !desc_stream.start_of_descriptor && phase_reg == eedp_pkg::PH_TRAILING
        |=> error_reg == $past(error_reg) && phase_reg == eedp_pkg::PH_TRAILING)
        else $error("trailing byte changed error flag or phase");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Extended event descriptor parser testbench
// Sends DVB extended event descriptors into the parser one byte at a time,
// both well-formed and damaged: truncated, overrunning and restarted. Both
// sides stall at random. A byte-level parse model predicts each tagged byte,
// and every tagged byte that leaves the parser is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned RANDOM_BYTES = 1200;

    typedef struct packed {
        logic [eedp_pkg::ROLE_W-1:0] role;
        logic [eedp_pkg::BYTE_W-1:0] value;
        logic [eedp_pkg::ITEM_W-1:0] item;
        logic [eedp_pkg::BYTE_W-1:0] char_pos;
        logic [eedp_pkg::NUM_W-1:0]  this_num;
        logic [eedp_pkg::NUM_W-1:0]  final_num;
        logic                        eod;
        logic                        err;
    } byte_tag_t;

    logic clk;
    logic rst_n;

    eedp_byte_if desc_if ();
    eedp_role_if tag_if ();

    extended_event_descriptor_parser_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_stream (desc_if),
        .role_stream (tag_if)
    );

    byte_tag_t   expected_tags[$];
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    bit          quiet;

    // parse state
    logic [eedp_pkg::ROLE_W-1:0] phase;
    logic [eedp_pkg::BYTE_W-1:0] field_left;
    logic [eedp_pkg::BYTE_W-1:0] items_left;
    logic [eedp_pkg::BYTE_W-1:0] desc_left;
    logic [eedp_pkg::ITEM_W-1:0] item_count;
    logic [eedp_pkg::BYTE_W-1:0] position;
    logic [eedp_pkg::BYTE_W-1:0] number_pair;
    logic                        err_flag;

    function automatic void reset_parser();
        phase       = eedp_pkg::PH_TRAILING;
        field_left  = '0;
        items_left  = '0;
        desc_left   = '0;
        item_count  = '0;
        position    = '0;
        number_pair = '0;
        err_flag    = 1'b0;
    endfunction

    function automatic logic take_desc();
        if (desc_left == '0)
        begin
            err_flag = 1'b1;
            return 1'b0;
        end
        desc_left = desc_left - 8'd1;
        return desc_left == '0;
    endfunction

    function automatic void take_item();
        if (items_left == '0)
            err_flag = 1'b1;
        else
            items_left = items_left - 8'd1;
    endfunction

    function automatic void end_item();
        if (item_count < eedp_pkg::ITEM_MAX)
            item_count = item_count + 7'd1;
        phase = (items_left == '0) ? eedp_pkg::PH_TEXT_LEN : eedp_pkg::PH_DESC_LEN;
    endfunction

    function automatic byte_tag_t parse_byte(input logic [eedp_pkg::BYTE_W-1:0] b,
                                             input logic s);
        byte_tag_t                   t;
        logic [eedp_pkg::ROLE_W-1:0] role;
        logic [eedp_pkg::BYTE_W-1:0] pos;
        logic                        last;
        pos  = '0;
        last = 1'b0;
        if (s)
        begin
            reset_parser();
            role  = eedp_pkg::PH_TAG;
            phase = eedp_pkg::PH_LENGTH;
        end
        else
        begin
            role = phase;
            case (phase)
                eedp_pkg::PH_LENGTH:
                begin
                    desc_left = b;
                    last      = (b == '0);
                    phase     = eedp_pkg::PH_NUMBERS;
                end
                eedp_pkg::PH_NUMBERS:
                begin
                    last        = take_desc();
                    number_pair = b;
                    position    = '0;
                    phase       = eedp_pkg::PH_LANG;
                end
                eedp_pkg::PH_LANG:
                begin
                    last     = take_desc();
                    pos      = position;
                    position = position + 8'd1;
                    if (position >= eedp_pkg::LANG_CHARS)
                        phase = eedp_pkg::PH_ITEMS_LEN;
                end
                eedp_pkg::PH_ITEMS_LEN:
                begin
                    last       = take_desc();
                    items_left = b;
                    phase      = (b == '0) ? eedp_pkg::PH_TEXT_LEN : eedp_pkg::PH_DESC_LEN;
                end
                eedp_pkg::PH_DESC_LEN, eedp_pkg::PH_ITEM_LEN:
                begin
                    last = take_desc();
                    take_item();
                    field_left = b;
                    position   = '0;
                    if (b != '0)
                        phase = phase + 4'd1;
                    else if (role == eedp_pkg::PH_DESC_LEN)
                        phase = eedp_pkg::PH_ITEM_LEN;
                    else
                        end_item();
                end
                eedp_pkg::PH_DESC_CHAR, eedp_pkg::PH_ITEM_CHAR:
                begin
                    last = take_desc();
                    take_item();
                    pos      = position;
                    position = position + 8'd1;
                    if (field_left != '0)
                        field_left = field_left - 8'd1;
                    if (field_left == '0)
                    begin
                        if (role == eedp_pkg::PH_DESC_CHAR)
                            phase = eedp_pkg::PH_ITEM_LEN;
                        else
                            end_item();
                    end
                end
                eedp_pkg::PH_TEXT_LEN:
                begin
                    last       = take_desc();
                    field_left = b;
                    position   = '0;
                    phase      = (b == '0) ? eedp_pkg::PH_TRAILING : eedp_pkg::PH_TEXT_CHAR;
                end
                eedp_pkg::PH_TEXT_CHAR:
                begin
                    last     = take_desc();
                    pos      = position;
                    position = position + 8'd1;
                    if (field_left != '0)
                        field_left = field_left - 8'd1;
                    if (field_left == '0)
                        phase = eedp_pkg::PH_TRAILING;
                end
                default:
                begin
                    role  = eedp_pkg::PH_TRAILING;
                    phase = eedp_pkg::PH_TRAILING;
                    if (desc_left != '0)
                    begin
                        desc_left = desc_left - 8'd1;
                        last      = (desc_left == '0);
                    end
                end
            endcase
        end
        t.role      = role;
        t.value     = b;
        t.item      = item_count;
        t.char_pos  = pos;
        t.this_num  = number_pair[7:4];
        t.final_num = number_pair[3:0];
        t.eod       = last;
        t.err       = err_flag;
        return t;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        tag_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tag_if.ready <= quiet || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin : track_results
        byte_tag_t got;
        byte_tag_t want;
        if (rst_n)
        begin
            if (tag_if.valid && tag_if.ready)
            begin
                got.role      = tag_if.byte_role;
                got.value     = tag_if.byte_value;
                got.item      = tag_if.item_number;
                got.char_pos  = tag_if.char_position;
                got.this_num  = tag_if.this_number;
                got.final_num = tag_if.final_number;
                got.eod       = tag_if.end_of_descriptor;
                got.err       = tag_if.length_error;
                if (expected_tags.size() == 0)
                begin
                    $error("unexpected transaction: byte_value %0d", got.value);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("byte_role", 32'(want.role), 32'(got.role));
                    check_field("byte_value", 32'(want.value), 32'(got.value));
                    check_field("item_number", 32'(want.item), 32'(got.item));
                    check_field("char_position", 32'(want.char_pos), 32'(got.char_pos));
                    check_field("this_number", 32'(want.this_num), 32'(got.this_num));
                    check_field("final_number", 32'(want.final_num), 32'(got.final_num));
                    check_field("end_of_descriptor", 32'(want.eod), 32'(got.eod));
                    check_field("length_error", 32'(want.err), 32'(got.err));
                end
            end
            if (desc_if.valid && desc_if.ready)
                expected_tags = {expected_tags,
                                 parse_byte(desc_if.data_byte,
                                            desc_if.start_of_descriptor)};
        end
    end

    task automatic send_byte(input logic [eedp_pkg::BYTE_W-1:0] b, input logic s);
        if (!quiet && $urandom_range(99) < 15)
        begin
            desc_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        desc_if.valid               <= 1'b1;
        desc_if.data_byte           <= b;
        desc_if.start_of_descriptor <= s;
        do
        begin
            @(posedge clk);
        end
        while (!desc_if.ready);
        bytes_sent++;
    endtask

    task automatic test_before_start();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
    endtask

    task automatic test_zero_length();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
    endtask

    task automatic test_full_descriptor();
        logic [eedp_pkg::BYTE_W-1:0] body[$];
        body = '{8'h5a, 8'h65, 8'h6e, 8'h67, 8'h06,
                 8'h01, 8'h61, 8'h00,
                 8'h00, 8'h01, 8'h78,
                 8'h02, 8'h68, 8'h69,
                 8'hff};
        send_byte(8'h4e, 1'b1);
        send_byte(8'h0e, 1'b0);
        foreach (body[i])
            send_byte(body[i], 1'b0);
    endtask

    task automatic test_overrun_restart();
        send_byte(8'hff, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h4e, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic send_descriptor(input bit saturate);
        logic [eedp_pkg::BYTE_W-1:0] body[$];
        logic [eedp_pkg::BYTE_W-1:0] loop_bytes[$];
        logic [eedp_pkg::BYTE_W-1:0] tag_byte;
        int unsigned                 len;
        int unsigned                 total;
        int unsigned                 fault;
        int unsigned                 cut;
        body = {body, 8'($urandom)};
        repeat (3) body = {body, 8'($urandom)};
        if (saturate || $urandom_range(99) < 2)
        begin
            repeat (256) loop_bytes = {loop_bytes, 8'h00};
            body = {body, 8'hff};
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                repeat (2)
                begin
                    len = ($urandom_range(99) < 70) ? $urandom_range(0, 3)
                                                    : $urandom_range(4, 20);
                    loop_bytes = {loop_bytes, 8'(len)};
                    repeat (len) loop_bytes = {loop_bytes, 8'($urandom)};
                end
            end
            body = {body, 8'(loop_bytes.size())};
        end
        body = {body, loop_bytes};
        len = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(4, 30);
        body = {body, 8'(len)};
        repeat (len) body = {body, 8'($urandom)};
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 3)) body = {body, 8'($urandom)};
        total = (body.size() > 255) ? 255 : body.size();

        fault = $urandom_range(99);
        if (fault < 5)
            body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
        else if (fault < 10)
        begin
            cut = $urandom_range(0, body.size() - 1);
            while (body.size() > cut)
                void'(body.pop_back());
        end
        else if (fault < 14)
            total = $urandom_range(0, 255);
        else if (fault < 18)
            body[4] = 8'($urandom);

        tag_byte = ($urandom_range(99) < 80) ? 8'h4e : 8'($urandom);
        send_byte(tag_byte, 1'b1);
        send_byte(8'(total), 1'b0);
        foreach (body[i])
            send_byte(body[i], 1'b0);
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_random_stream();
        int unsigned base;
        int unsigned count;
        base  = bytes_sent;
        count = 0;
        while (bytes_sent - base < RANDOM_BYTES)
        begin
            quiet = (bytes_sent - base >= 500) && (bytes_sent - base < 750);
            send_descriptor(count == 2);
            count++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        desc_if.valid               <= 1'b0;
        desc_if.data_byte           <= '0;
        desc_if.start_of_descriptor <= 1'b0;
        quiet      = 1'b0;
        mismatches = 0;
        bytes_sent = 0;
        reset_parser();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_start();
        test_zero_length();
        test_full_descriptor();
        test_overrun_restart();
        test_random_stream();

        desc_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
